// ===== hdl/ballast_tank_stepper_control_defines.svh =====
// ----------------------------------------------------------------------------
// Ballast tank stepper control - assertion macros
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BALLAST_TANK_STEPPER_CONTROL_DEFINES_SVH
`define BALLAST_TANK_STEPPER_CONTROL_DEFINES_SVH

// Same-cycle implication, masked while reset is active
`define BTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bts assertion failed");

// Next-cycle implication, masked while reset is active
`define BTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bts assertion failed");

// Next-cycle implication that also holds across reset
`define BTS_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bts reset assertion failed");

`endif

// ===== hdl/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// Ballast tank stepper control - package
// Item types, mode and state codes, and saturation helper.
// ----------------------------------------------------------------------------
package bts_pkg;

    // Item modes
    localparam logic [2:0] MODE_FILL_BY   = 3'd0;
    localparam logic [2:0] MODE_DRAIN_BY  = 3'd1;
    localparam logic [2:0] MODE_FILL_TO   = 3'd2;
    localparam logic [2:0] MODE_DRAIN_TO  = 3'd3;
    localparam logic [2:0] MODE_UPDATE    = 3'd4;
    localparam logic [2:0] MODE_FULL_SW   = 3'd5;
    localparam logic [2:0] MODE_EMPTY_SW  = 3'd6;

    // Step rate = (RATE_FACTOR * velocity) >> 8
    localparam int unsigned RATE_FACTOR = 3200;
    localparam logic [15:0] VELOCITY_RESET = 16'd256;

    typedef enum logic [2:0] {
        ST_MID      = 3'd0,
        ST_FILLING  = 3'd1,
        ST_DRAINING = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } t_tank_state;

    typedef struct packed {
        logic [2:0]         mode;
        logic [23:0]        amount;
        logic signed [31:0] target_volume;
        logic [31:0]        finished_steps;
    } t_in_item;

    typedef struct packed {
        logic               cmd_valid;
        logic               cmd_direction;
        logic [31:0]        cmd_steps;
        logic [19:0]        cmd_rate;
        logic               stop_motor;
        logic [2:0]         tank_status;
        logic signed [31:0] current_volume;
    } t_out_item;

    // Clamp a 34-bit signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/bts_core.sv =====
// ----------------------------------------------------------------------------
// Ballast tank stepper control - core
// Input register, tank state and the single-pass command/update logic.
// ----------------------------------------------------------------------------
module bts_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_in_valid,
    input  bts_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    output logic              o_res_valid,
    output bts_pkg::t_out_item o_res_item,
    input  logic              i_res_ready
);
    import bts_pkg::*;

    logic               r_in_vld;
    t_in_item           r_in;
    logic [15:0]        r_velocity;
    t_tank_state        r_tank_state, n_tank_state;
    logic signed [31:0] r_volume, n_volume;
    logic signed [31:0] r_target, n_target;
    logic [31:0]        r_last_steps, n_last_steps;
    logic               r_pend_full, n_pend_full;
    logic               r_pend_empty, n_pend_empty;

    logic               w_advance;
    logic               w_issue;
    logic               w_stop;
    logic signed [33:0] w_vol34;
    logic signed [31:0] w_fill_tgt, w_drain_tgt;
    logic [31:0]        w_delta;
    logic signed [31:0] w_vol_add, w_vol_sub;
    logic signed [32:0] w_diff;
    logic [32:0]        w_mag;
    logic [27:0]        w_rate_prod;

    // Item leaves the input register when the output side can take it
    assign w_advance   = r_in_vld && i_res_ready;
    assign o_in_stall  = r_in_vld && !i_res_ready;
    assign o_res_valid = r_in_vld;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Velocity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_velocity <= VELOCITY_RESET;
        end else if (i_cfg_we) begin
            r_velocity <= i_cfg_wdata;
        end
    end

    // Saturated candidates
    assign w_vol34     = 34'(r_volume);
    assign w_fill_tgt  = sat32(w_vol34 + $signed({10'd0, r_in.amount}));
    assign w_drain_tgt = sat32(w_vol34 - $signed({10'd0, r_in.amount}));
    assign w_delta     = r_in.finished_steps - r_last_steps;
    assign w_vol_add   = sat32(w_vol34 + $signed({2'd0, w_delta}));
    assign w_vol_sub   = sat32(w_vol34 - $signed({2'd0, w_delta}));

    // Next state
    always_comb begin
        n_tank_state = r_tank_state;
        n_volume     = r_volume;
        n_target     = r_target;
        n_last_steps = r_last_steps;
        n_pend_full  = r_pend_full;
        n_pend_empty = r_pend_empty;
        w_issue      = 1'b0;
        w_stop       = 1'b0;
        case (r_in.mode)
            MODE_FILL_BY: begin
                if (r_in.amount != 24'd0 && r_tank_state != ST_FULL) begin
                    n_target     = w_fill_tgt;
                    n_tank_state = ST_FILLING;
                    w_issue      = 1'b1;
                end
            end
            MODE_DRAIN_BY: begin
                if (r_in.amount != 24'd0 && r_tank_state != ST_EMPTY) begin
                    n_target     = w_drain_tgt;
                    n_tank_state = ST_DRAINING;
                    w_issue      = 1'b1;
                end
            end
            MODE_FILL_TO: begin
                if (r_tank_state != ST_FULL) begin
                    n_target = r_in.target_volume;
                    w_issue  = 1'b1;
                end
            end
            MODE_DRAIN_TO: begin
                if (r_tank_state != ST_EMPTY) begin
                    n_target = r_in.target_volume;
                    w_issue  = 1'b1;
                end
            end
            MODE_UPDATE: begin
                if (r_pend_full) begin
                    // full wins; a pending empty waits for a later tick
                    n_pend_full  = 1'b0;
                    n_tank_state = ST_FULL;
                    n_last_steps = 32'd0;
                    w_stop       = 1'b1;
                end else if (r_pend_empty) begin
                    n_pend_empty = 1'b0;
                    n_tank_state = ST_EMPTY;
                    n_volume     = 32'sd0;
                    n_last_steps = 32'd0;
                    w_stop       = 1'b1;
                end else if (r_in.finished_steps != 32'd0) begin
                    if (r_tank_state == ST_DRAINING) begin
                        n_volume = w_vol_sub;
                    end else if (r_tank_state == ST_FILLING) begin
                        n_volume = w_vol_add;
                    end
                    n_last_steps = r_in.finished_steps;
                end else begin
                    // motor idle: moving states fall back to mid
                    if (r_tank_state == ST_FILLING || r_tank_state == ST_DRAINING) begin
                        n_tank_state = ST_MID;
                    end
                    n_last_steps = 32'd0;
                end
            end
            MODE_FULL_SW: begin
                n_pend_full = 1'b1;
            end
            MODE_EMPTY_SW: begin
                n_pend_empty = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Command fields from the new target and the pre-item volume
    assign w_diff      = 33'(n_target) - 33'(r_volume);
    assign w_mag       = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_rate_prod = 28'(r_velocity) * 28'(RATE_FACTOR);

    // Result item
    always_comb begin
        o_res_item                = '0;
        o_res_item.stop_motor     = w_stop;
        o_res_item.tank_status    = n_tank_state;
        o_res_item.current_volume = n_volume;
        if (w_issue) begin
            o_res_item.cmd_valid     = 1'b1;
            o_res_item.cmd_direction = !w_diff[32] && (w_diff != 33'sd0);
            o_res_item.cmd_steps     = w_mag[31:0];
            o_res_item.cmd_rate      = w_rate_prod[27:8];
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tank_state <= ST_MID;
            r_volume     <= 32'sd0;
            r_target     <= 32'sd0;
            r_last_steps <= 32'd0;
            r_pend_full  <= 1'b0;
            r_pend_empty <= 1'b0;
        end else if (w_advance) begin
            r_tank_state <= n_tank_state;
            r_volume     <= n_volume;
            r_target     <= n_target;
            r_last_steps <= n_last_steps;
            r_pend_full  <= n_pend_full;
            r_pend_empty <= n_pend_empty;
        end
    end

endmodule

// ===== hdl/bts_out.sv =====
// ----------------------------------------------------------------------------
// Ballast tank stepper control - result register
// Holds one result item toward the receiver; refills while it drains.
// ----------------------------------------------------------------------------
module bts_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bts_pkg::t_out_item i_item,
    output logic               o_ready,
    output logic               o_valid,
    output bts_pkg::t_out_item o_item,
    input  logic               i_stall
);
    import bts_pkg::*;

    logic      r_vld;
    t_out_item r_item;

    // Empty, or the held item leaves this cycle
    assign o_ready = !r_vld || !i_stall;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hdl/ballast_tank_stepper_control.sv =====
// ----------------------------------------------------------------------------
// Ballast tank stepper control - top level
// Tracks one stepper-driven ballast tank in motor steps and issues moves.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): one item per
//   command, limit-switch event or update tick. Output channel
//   (o_out_valid / i_out_stall / o_out_item): exactly one result item per
//   input item, in order. An item moves when valid is high and stall low.
//   Velocity (8.8 ml/s) is written through i_cfg_we / i_cfg_wdata while
//   the block is idle; it sets the step rate of later move commands.
//   Path: an accepted item is held in the input register, then in the
//   result register, from which the receiver takes it.
//   Throughput: one item per cycle while i_out_stall is low; the tank state
//   update, target saturation and |target - volume| all sit in the single
//   logic stage between the two registers.
//   Reset: tank goes to mid, volume/target/step count zero, no pending
//   limit events, velocity 1.0; both item registers empty.
//   Receiver stall: the result register holds; the input register keeps
//   its item, and o_in_stall rises only once both registers are full.
// ----------------------------------------------------------------------------
module ballast_tank_stepper_control (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bts_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bts_pkg::t_out_item o_out_item
);
    import bts_pkg::*;

    logic      w_res_valid;
    logic      w_res_ready;
    t_out_item w_res_item;

    bts_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_res_valid (w_res_valid),
        .o_res_item  (w_res_item),
        .i_res_ready (w_res_ready)
    );

    bts_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_item  (w_res_item),
        .o_ready (w_res_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule

// ===== hdl/bts_checker.sv =====
// ----------------------------------------------------------------------------
// Ballast tank stepper control - port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "ballast_tank_stepper_control_defines.svh"

module bts_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bts_pkg::t_out_item o_out_item
);
    import bts_pkg::*;

    // Stalled result holds
    `BTS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // No command means zeroed command fields
    `BTS_ASSERT_NOW(a_cmd_zero, i_clk, i_rst_n, o_out_valid && !o_out_item.cmd_valid, !o_out_item.cmd_direction && o_out_item.cmd_steps == 32'd0 && o_out_item.cmd_rate == 20'd0)

    // A stop lands the tank at a limit and never comes with a move
    `BTS_ASSERT_NOW(a_stop_limit, i_clk, i_rst_n, o_out_valid && o_out_item.stop_motor, !o_out_item.cmd_valid && (o_out_item.tank_status == ST_FULL || o_out_item.tank_status == ST_EMPTY))

    // Empty stop zeroes the tracked volume
    `BTS_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_out_valid && o_out_item.stop_motor && o_out_item.tank_status == ST_EMPTY, o_out_item.current_volume == 32'sd0)

    // Reset empties the result register
    `BTS_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind ballast_tank_stepper_control bts_checker u_bts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
